@@ rtl/vcrp_pkg.sv @@
// ----------------------------------------------------------------------------
// vcrp_pkg: voltage/current report parser definitions
// Shared widths, character codes and parser phase codes.
// ----------------------------------------------------------------------------
package vcrp_pkg;

  localparam int unsigned VALUE_BITS = 24;
  localparam int unsigned OUT_BITS   = 24;
  localparam int unsigned BYTE_BITS  = 8;
  // Enough headroom for acc * 10 + 9.
  localparam int unsigned WIDE_BITS  = VALUE_BITS + 4;

  localparam logic [VALUE_BITS-1:0] ACC_MAX = {VALUE_BITS{1'b1}};

  localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_BITS-1:0] CH_M     = 8'h6D;
  localparam logic [BYTE_BITS-1:0] CH_V     = 8'h56;
  localparam logic [BYTE_BITS-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_VNUM = 3'd1,
    PH_VM   = 3'd2,
    PH_MV   = 3'd3,
    PH_ANUM = 3'd4,
    PH_AM   = 3'd5,
    PH_ERR  = 3'd6
  } phase_e;

endpackage

@@ rtl/voltage_current_report_parser_unit.sv @@
// ----------------------------------------------------------------------------
// voltage_current_report_parser_unit
// Parses <digits>mV<whitespace><digits>mA reports from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one ASCII byte per item (in_valid_i,
//   in_ready_o, byte_in_i). The output channel carries one item per
//   completed report (out_valid_o, out_ready_i, millivolts_o, milliamps_o).
//   Both values saturate at all ones and are the low 24 bits of the
//   internal accumulators.
//   A byte is captured in an input register, then parsed from there by the
//   phase update logic, which also loads the result register. The closing
//   'A' thus passes the input register, then the result register, before it
//   shows up as a result item. One byte is taken every cycle unless a waiting
//   result stalls; the only loop is the phase and accumulator update.
//   While the receiver stalls with a result waiting, parsing stops and at
//   most one byte waits in the input register; once it is full, in_ready_o
//   stays low until the result is taken.
//   Reset puts the parser in the idle phase, clears both accumulators and
//   empties the input and result registers.
// ----------------------------------------------------------------------------
module voltage_current_report_parser_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [vcrp_pkg::BYTE_BITS-1:0]   byte_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [vcrp_pkg::OUT_BITS-1:0]    millivolts_o,
  output logic [vcrp_pkg::OUT_BITS-1:0]    milliamps_o
);
  import vcrp_pkg::*;

  logic                  in_valid_q;
  logic [BYTE_BITS-1:0]  byte_q;
  phase_e                phase_q, phase_d;
  logic [VALUE_BITS-1:0] volt_q, volt_d;
  logic [VALUE_BITS-1:0] amp_q, amp_d;
  logic                  out_valid_q;
  logic [OUT_BITS-1:0]   mv_q, ma_q;

  logic                  advance;
  logic                  emit;
  logic                  is_dig;
  logic                  is_ws;
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] push_src;
  logic [WIDE_BITS-1:0]  push_wide;
  logic [VALUE_BITS-1:0] push_val;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign is_dig = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign is_ws  = (byte_q == CH_SPACE) || ((byte_q >= CH_TAB) && (byte_q <= CH_CR));
  assign digit  = is_dig ? 4'(byte_q - CH_ZERO) : 4'd0;

  // One shared digit push: acc * 10 + d, saturating at the maximum.
  assign push_src  = (phase_q == PH_ANUM) ? amp_q : volt_q;
  assign push_wide = (WIDE_BITS'(push_src) << 3) + (WIDE_BITS'(push_src) << 1)
                     + WIDE_BITS'(digit);
  assign push_val  = (push_wide > WIDE_BITS'(ACC_MAX)) ? ACC_MAX
                                                        : push_wide[VALUE_BITS-1:0];

  always_comb begin
    phase_d = phase_q;
    volt_d  = volt_q;
    amp_d   = amp_q;
    emit    = 1'b0;
    case (phase_q)
      PH_VNUM: begin
        if (is_dig) begin
          volt_d = push_val;
        end else begin
          phase_d = (byte_q == CH_M) ? PH_VM : PH_ERR;
        end
      end
      PH_VM: begin
        phase_d = (byte_q == CH_V) ? PH_MV : PH_ERR;
      end
      PH_MV: begin
        if (is_dig) begin
          amp_d   = VALUE_BITS'(digit);
          phase_d = PH_ANUM;
        end else if (!is_ws) begin
          phase_d = PH_ERR;
        end
      end
      PH_ANUM: begin
        if (is_dig) begin
          amp_d = push_val;
        end else begin
          phase_d = (byte_q == CH_M) ? PH_AM : PH_ERR;
        end
      end
      PH_AM: begin
        if (byte_q == CH_A) begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_ERR;
        end
      end
      PH_ERR: begin
        if (byte_q == CH_A) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        // Idle, and the unused code behaves the same way.
        if (is_dig) begin
          volt_d  = VALUE_BITS'(digit);
          phase_d = PH_VNUM;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_IDLE;
      volt_q      <= '0;
      amp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q <= phase_d;
        volt_q  <= volt_d;
        amp_q   <= amp_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
    if (advance && emit) begin
      mv_q <= OUT_BITS'(volt_q);
      ma_q <= OUT_BITS'(amp_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign millivolts_o = mv_q;
  assign milliamps_o  = ma_q;

`ifndef SYNTHESIS
  a_result_from_unit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(phase_q) == PH_AM)
    else $error("result item loaded outside the unit phase");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a waiting result");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (phase_q == PH_IDLE) && out_valid_q)
    else $error("parser did not return to idle after a result");
`endif

endmodule

@@ verif/vcrp_report_checker.sv @@
// ----------------------------------------------------------------------------
// vcrp_report_checker
// Watches the byte and result channels of the report parser, keeps its own
// copy of the parser phase and accumulators, and compares every result item
// with the oldest report expected from the bytes taken so far.
// ----------------------------------------------------------------------------
module vcrp_report_checker
  import vcrp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [BYTE_BITS-1:0]  byte_in_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_BITS-1:0]   millivolts_i,
  input  logic [OUT_BITS-1:0]   milliamps_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    reports_o
);

  typedef struct packed {
    logic [OUT_BITS-1:0] millivolts;
    logic [OUT_BITS-1:0] milliamps;
  } report_t;

  phase_e                phase_q;
  logic [VALUE_BITS-1:0] volt_sum;
  logic [VALUE_BITS-1:0] amp_sum;
  report_t               expected_reports[$];
  int                    mismatches;
  int                    reports_seen;

  // Decimal shift with saturation at all ones.
  function automatic logic [VALUE_BITS-1:0] append_digit(input logic [VALUE_BITS-1:0] acc,
                                                          input logic [3:0] digit);
    if (acc > (ACC_MAX - digit) / 10) begin
      return ACC_MAX;
    end
    return VALUE_BITS'(acc * 10 + digit);
  endfunction

  task automatic parse_char(input logic [BYTE_BITS-1:0] ch);
    logic       is_digit;
    logic       is_space;
    logic [3:0] digit;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    digit    = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
    case (phase_q)
      PH_VNUM: begin
        if (is_digit) volt_sum = append_digit(volt_sum, digit);
        else phase_q = (ch == CH_M) ? PH_VM : PH_ERR;
      end
      PH_VM: phase_q = (ch == CH_V) ? PH_MV : PH_ERR;
      PH_MV: begin
        if (is_digit) begin
          amp_sum = VALUE_BITS'(digit);
          phase_q = PH_ANUM;
        end else if (!is_space) begin
          phase_q = PH_ERR;
        end
      end
      PH_ANUM: begin
        if (is_digit) amp_sum = append_digit(amp_sum, digit);
        else phase_q = (ch == CH_M) ? PH_AM : PH_ERR;
      end
      PH_AM: begin
        if (ch == CH_A) begin
          expected_reports.push_back('{volt_sum[OUT_BITS-1:0], amp_sum[OUT_BITS-1:0]});
          phase_q = PH_IDLE;
        end else begin
          phase_q = PH_ERR;
        end
      end
      PH_ERR: begin
        if (ch == CH_A) phase_q = PH_IDLE;
      end
      // Idle, and the unused phase code, which behaves the same way.
      default: begin
        if (is_digit) begin
          volt_sum = VALUE_BITS'(digit);
          phase_q  = PH_VNUM;
        end else begin
          phase_q = PH_IDLE;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    report_t want;
    if (!rst_ni) begin
      phase_q  = PH_IDLE;
      volt_sum = '0;
      amp_sum  = '0;
      expected_reports.delete();
      mismatches   = 0;
      reports_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      reports_o    <= 0;
    end else begin
      // A result always trails its closing byte, so results are checked first.
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $error("unexpected result: millivolts %0d, milliamps %0d",
                 millivolts_i, milliamps_i);
        end else begin
          want = expected_reports.pop_front();
          reports_seen++;
          if (millivolts_i !== want.millivolts) begin
            mismatches++;
            $error("millivolts: expected %0d, actual %0d", want.millivolts, millivolts_i);
          end
          if (milliamps_i !== want.milliamps) begin
            mismatches++;
            $error("milliamps: expected %0d, actual %0d", want.milliamps, milliamps_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_char(byte_in_i);
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_reports.size();
      reports_o    <= reports_seen;
    end
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Feeds the report parser with directed byte strings, then with random
// reports, corrupted reports and noise, under random idling on both
// channels. Checking is done by vcrp_report_checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import vcrp_pkg::*;

  localparam int RANDOM_BYTES = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [BYTE_BITS-1:0] byte_in_i   = '0;
  logic                 out_ready_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [OUT_BITS-1:0]  millivolts_o;
  logic [OUT_BITS-1:0]  milliamps_o;

  int fail_count;
  int pending;
  int reports_done;
  int bytes_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  logic [BYTE_BITS-1:0] frame_bytes[$];

  voltage_current_report_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .millivolts_o (millivolts_o),
    .milliamps_o  (milliamps_o)
  );

  vcrp_report_checker report_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .millivolts_i (millivolts_o),
    .milliamps_i  (milliamps_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .reports_o    (reports_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("voltage_current_report_parser_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 19);
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic add_number();
    longint unsigned val;
    string           digits;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(5))
        0:       val = 0;
        1:       val = 64'd1677721;
        2:       val = 64'd16777214;
        3:       val = 64'd16777215;
        4:       val = 64'd16777216;
        default: val = 64'd4294967295;
      endcase
    end else if (pick < 30) begin
      val = {$urandom, $urandom} % 64'd10000000000;
    end else begin
      val = $urandom_range(99999);
    end
    digits = $sformatf("%0d", val);
    if ($urandom_range(9) == 0) digits = {"0", digits};
    add_text(digits);
  endtask

  // A well-formed report with optional junk ahead of the first digit.
  task automatic add_report();
    logic [BYTE_BITS-1:0] b;
    int unsigned          pick;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        do b = BYTE_BITS'($urandom_range(255)); while (b >= CH_ZERO && b <= CH_NINE);
        frame_bytes.push_back(b);
      end
    end
    add_number();
    add_text("mV");
    repeat ($urandom_range(2)) begin
      pick = $urandom_range(5);
      frame_bytes.push_back(pick == 5 ? CH_SPACE : CH_TAB + BYTE_BITS'(pick));
    end
    add_number();
    add_text("mA");
  endtask

  task automatic send_byte(input logic [BYTE_BITS-1:0] b);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_frame();
    while (frame_bytes.size() > 0) send_byte(frame_bytes.pop_front());
  endtask

  initial begin
    int unsigned roll;
    int unsigned idx;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes while idle, digit bounds, tab and carriage
    // return separators, an overflowing voltage and an error dropped at 'A'.
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    add_text("0mV");
    frame_bytes.push_back(CH_TAB);
    add_text("9mA16777216mV");
    frame_bytes.push_back(CH_CR);
    add_text("0mA5xA");
    send_frame();

    while (bytes_sent < RANDOM_BYTES) begin
      // One stretch of the run goes without any idling on either side.
      calm = (bytes_sent >= 250) && (bytes_sent < 400);
      roll = $urandom_range(99);
      if (roll < 85) begin
        add_report();
        if (roll >= 70) begin
          idx = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[idx] = BYTE_BITS'($urandom_range(255));
        end
      end else begin
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(BYTE_BITS'($urandom_range(255)));
      end
      send_frame();
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // The checker counts the last byte's report at the edge just passed.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes: directed strings, random reports, corrupted reports, noise.",
             bytes_sent);
    $display("Compared %0d reports; %0d mismatches.", reports_done, fail_count);
    if (fail_count == 0) begin
      $display("voltage_current_report_parser_unit verification clean");
    end else begin
      $display("voltage_current_report_parser_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/vcrp_pkg.sv
rtl/voltage_current_report_parser_unit.sv
verif/vcrp_report_checker.sv
verif/testbench.sv
